// ----- src/cars_pkg.sv -----
`default_nettype none
package cars_pkg;

    // Fixed widths of the row and register fields
    localparam int ROW_W     = 64;
    localparam int WIDTH_W   = 7;
    localparam int THRESH_W  = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Largest map width supported by default
    localparam int MAX_WIDTH_DEF = 64;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_KEEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FILL  = 2'd2;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  MAP_WIDTH_RST  = 7'd64;
    localparam logic [THRESH_W-1:0] WALL_KEEP_RST  = 4'd4;
    localparam logic [THRESH_W-1:0] FLOOR_FILL_RST = 4'd5;

    // Settings the smoother needs for one row
    typedef struct packed {
        logic [WIDTH_W-1:0]  map_width;
        logic [THRESH_W-1:0] wall_keep;
        logic [THRESH_W-1:0] floor_fill;
    } smooth_cfg_t;

endpackage
`default_nettype wire

// ----- src/cars_smoother.sv -----
`default_nettype none
module cars_smoother #(
    parameter int MAX_WIDTH = cars_pkg::MAX_WIDTH_DEF
) (
    input  wire logic [cars_pkg::ROW_W-1:0] up_row,
    input  wire logic                       up_inside,
    input  wire logic [cars_pkg::ROW_W-1:0] mid_row,
    input  wire logic [cars_pkg::ROW_W-1:0] down_row,
    input  wire logic                       down_inside,
    input  wire cars_pkg::smooth_cfg_t      cfg,
    output logic      [cars_pkg::ROW_W-1:0] new_row
);
    import cars_pkg::*;

    localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

    logic [WIDTH_W-1:0] eff_w;
    logic [ROW_W-1:0]   col_inside;
    logic [ROW_W+1:0]   up_ext;
    logic [ROW_W+1:0]   mid_ext;
    logic [ROW_W+1:0]   down_ext;

    // Clamp the width into 1..MAX_WIDTH
    always_comb begin
        if (cfg.map_width == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (cfg.map_width > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = cfg.map_width;
        end
    end

    // Rows padded by one column each side; anything outside the map reads as wall
    assign up_ext[0]         = 1'b1;
    assign up_ext[ROW_W+1]   = 1'b1;
    assign mid_ext[0]        = 1'b1;
    assign mid_ext[ROW_W+1]  = 1'b1;
    assign down_ext[0]       = 1'b1;
    assign down_ext[ROW_W+1] = 1'b1;

    for (genvar c = 0; c < ROW_W; c++) begin : g_cell
        logic [CNT_W-1:0] cnt;
        logic             becomes;

        assign col_inside[c]  = (WIDTH_W'(c) < eff_w);
        assign up_ext[c+1]    = !up_inside | !col_inside[c] | up_row[c];
        assign mid_ext[c+1]   = !col_inside[c] | mid_row[c];
        assign down_ext[c+1]  = !down_inside | !col_inside[c] | down_row[c];

        // Moore neighbourhood wall count
        assign cnt = CNT_W'(up_ext[c])   + CNT_W'(up_ext[c+1])   + CNT_W'(up_ext[c+2])
                   + CNT_W'(down_ext[c]) + CNT_W'(down_ext[c+1]) + CNT_W'(down_ext[c+2])
                   + CNT_W'(mid_ext[c])  + CNT_W'(mid_ext[c+2]);

        assign becomes    = mid_row[c] ? (cnt >= cfg.wall_keep) : (cnt >= cfg.floor_fill);
        assign new_row[c] = col_inside[c] & becomes;
    end

endmodule
`default_nettype wire

// ----- src/cave_automaton_row_smoother.sv -----
`default_nettype none
// Row smoother for a cave wall map: one generation of the Moore-neighbourhood
// cave automaton, one row per input beat, bit c set meaning wall. A row is
// accepted every cycle while the output queue has two free slots; its result
// (the smoothed row above it) enters a four-entry output queue at the edge
// that accepts the row and reaches the m_ side once earlier beats have left.
// A row marked final_row yields the held row, when there is one, followed by
// itself, the last beat flagged frame_done; the first row of a map yields
// nothing unless it is also final, and then gives a single beat. With m_ready
// held high the block sustains one row per cycle; the queue depth sets how far
// a stalled consumer can fall behind before s_ready drops. Configuration
// writes are taken in any cycle and should be made while no map is in flight.
module cave_automaton_row_smoother #(
    parameter int MAX_WIDTH = cars_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // row input
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cars_pkg::ROW_W-1:0]      s_row_cells,
    input  wire logic                            s_final_row,
    // row output
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [cars_pkg::ROW_W-1:0]      m_new_row_cells,
    output logic                                 m_frame_done,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cars_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cars_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cars_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    logic [WIDTH_W-1:0]  map_width_reg;
    logic [THRESH_W-1:0] wall_keep_reg;
    logic [THRESH_W-1:0] floor_fill_reg;
    smooth_cfg_t         cfg;

    logic [ROW_W-1:0] row_above_reg,  row_above_next;
    logic [ROW_W-1:0] row_middle_reg, row_middle_next;
    logic             above_present_reg, above_present_next;
    logic             middle_present_reg, middle_present_next;

    logic [ROW_W-1:0] res_upper;
    logic [ROW_W-1:0] res_final;
    logic [ROW_W-1:0] flush_above;

    logic [ROW_W-1:0]  q_rows_reg [QDEPTH];
    logic              q_done_reg [QDEPTH];
    logic [QPTR_W-1:0] q_wr_reg, q_wr_next;
    logic [QPTR_W-1:0] q_rd_reg, q_rd_next;
    logic [QCNT_W-1:0] q_cnt_reg, q_cnt_next;

    logic in_beat;
    logic out_beat;
    logic push_upper;
    logic push_final;
    logic [QPTR_W-1:0] final_slot;

    assign in_beat  = s_valid & s_ready;
    assign out_beat = m_valid & m_ready;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_WIDTH_RST;
            wall_keep_reg  <= WALL_KEEP_RST;
            floor_fill_reg <= FLOOR_FILL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_WALL_KEEP:  wall_keep_reg  <= cfg_data[THRESH_W-1:0];
                REG_FLOOR_FILL: floor_fill_reg <= cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.map_width  = map_width_reg;
    assign cfg.wall_keep  = wall_keep_reg;
    assign cfg.floor_fill = floor_fill_reg;

    // Held row, with the incoming row as its lower neighbour
    cars_smoother #(.MAX_WIDTH(MAX_WIDTH)) u_smooth_upper (
        .up_row      (row_above_reg),
        .up_inside   (above_present_reg),
        .mid_row     (row_middle_reg),
        .down_row    (s_row_cells),
        .down_inside (1'b1),
        .cfg         (cfg),
        .new_row     (res_upper)
    );

    // Incoming row as the last of the map, bottom border below it
    assign flush_above = middle_present_reg ? row_middle_reg : '0;

    cars_smoother #(.MAX_WIDTH(MAX_WIDTH)) u_smooth_final (
        .up_row      (flush_above),
        .up_inside   (middle_present_reg),
        .mid_row     (s_row_cells),
        .down_row    ('0),
        .down_inside (1'b0),
        .cfg         (cfg),
        .new_row     (res_final)
    );

    // Row window update
    always_comb begin
        row_above_next      = row_above_reg;
        row_middle_next     = row_middle_reg;
        above_present_next  = above_present_reg;
        middle_present_next = middle_present_reg;
        if (in_beat) begin
            if (s_final_row) begin
                row_above_next      = '0;
                row_middle_next     = '0;
                above_present_next  = 1'b0;
                middle_present_next = 1'b0;
            end else begin
                row_above_next      = flush_above;
                row_middle_next     = s_row_cells;
                above_present_next  = middle_present_reg;
                middle_present_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_present_reg  <= 1'b0;
            middle_present_reg <= 1'b0;
        end else begin
            above_present_reg  <= above_present_next;
            middle_present_reg <= middle_present_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_above_reg  <= row_above_next;
        row_middle_reg <= row_middle_next;
    end

    // Output queue: up to two beats in, one beat out per cycle while m_ready is high
    assign push_upper = in_beat & middle_present_reg;
    assign push_final = in_beat & s_final_row;
    assign final_slot = push_upper ? q_wr_reg + QPTR_W'(1) : q_wr_reg;

    assign s_ready = (q_cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign m_valid = (q_cnt_reg != '0);
    assign m_new_row_cells = q_rows_reg[q_rd_reg];
    assign m_frame_done    = q_done_reg[q_rd_reg];

    always_comb begin
        q_wr_next  = q_wr_reg + QPTR_W'(push_upper) + QPTR_W'(push_final);
        q_rd_next  = q_rd_reg + QPTR_W'(out_beat);
        q_cnt_next = q_cnt_reg + QCNT_W'(push_upper) + QCNT_W'(push_final)
                   - QCNT_W'(out_beat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            q_wr_reg  <= q_wr_next;
            q_rd_reg  <= q_rd_next;
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_upper) begin
            q_rows_reg[q_wr_reg] <= res_upper;
            q_done_reg[q_wr_reg] <= 1'b0;
        end
        if (push_final) begin
            q_rows_reg[final_slot] <= res_final;
            q_done_reg[final_slot] <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- src/cars_checker.sv -----
`default_nettype none
module cars_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       s_final_row,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [cars_pkg::ROW_W-1:0] m_new_row_cells,
    input wire logic                       m_frame_done
);

    // Queue is empty straight after reset
    a_idle_after_reset: assert property (
        @(posedge aclk) !aresetn |=> (s_ready && !m_valid)
    ) else $error("block not idle after reset");

    // A final row always produces at least one beat
    a_final_gives_beat: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_final_row) |=> m_valid
    ) else $error("final row produced no result");

    // Input stalls only when output beats are pending
    a_stall_needs_backlog: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid
    ) else $error("input stalled with nothing to deliver");

    // Stalled result beat holds
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_new_row_cells)
                                   && $stable(m_frame_done))
    ) else $error("result beat changed while stalled");

endmodule

bind cave_automaton_row_smoother cars_checker u_cars_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_final_row     (s_final_row),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_new_row_cells (m_new_row_cells),
    .m_frame_done    (m_frame_done)
);
`default_nettype wire
